@@ hw/rtl/lsa_pkg.sv @@
`default_nettype none
package lsa_pkg;

   localparam int GRID_MAX_DEF  = 64;
   localparam int AGENT_MAX_DEF = 1024;

   localparam int CSR_AW = 2;
   localparam int CSR_DW = 16;
   localparam logic [6:0] SIDE_RESET = 7'd64;

   localparam int REQ_W = 48;
   localparam int RSP_W = 56;
   localparam int CNT_W = 11;
   localparam int PROB_W = 16;
   localparam int POW_W = 17;

   typedef enum logic [CSR_AW-1:0] {
      REG_GRID_SIDE = 2'd0,
      REG_INFECT    = 2'd1,
      REG_ONSET     = 2'd2,
      REG_RECOVER   = 2'd3
   } csr_reg_type;

   typedef enum logic [1:0] {
      CMD_PLACE  = 2'd0,
      CMD_MOVE   = 2'd1,
      CMD_UPDATE = 2'd2
   } cmd_type;

   // cell and agent disease codes; zero marks an empty cell
   localparam logic [2:0] HS_EMPTY = 3'd0;
   localparam logic [2:0] HS_S     = 3'd1;
   localparam logic [2:0] HS_E     = 3'd2;
   localparam logic [2:0] HS_I     = 3'd3;
   localparam logic [2:0] HS_R     = 3'd4;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_REDUCE,
      ST_AREAD,
      ST_DECODE,
      ST_PCHK,
      ST_PSET,
      ST_MCHK,
      ST_MCLR,
      ST_NB,
      ST_POW,
      ST_UWR,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic       start;
      logic [2:0] n;
   } pow_cmd_type;

endpackage
`default_nettype wire

@@ hw/rtl/lsa_pow.sv @@
`default_nettype none
// Raise q to the n-th power, one truncating Q1.16 product per cycle.
module lsa_pow (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire lsa_pkg::pow_cmd_type        pow_cmd,
   input  wire logic [lsa_pkg::POW_W-1:0]   q,
   output logic                             pow_done,
   output logic [lsa_pkg::POW_W-1:0]        pw
);

   logic                        busy_ff, busy_in;
   logic [1:0]                  k_ff, k_in;
   logic [lsa_pkg::POW_W-1:0]   pw_ff, pw_in;
   logic [2*lsa_pkg::POW_W-1:0] prod;

   assign prod     = pw_ff * q;
   assign pow_done = busy_ff && (k_ff == 2'd0);
   assign pw       = pw_ff;

   always_comb begin
      busy_in = busy_ff;
      k_in    = k_ff;
      pw_in   = pw_ff;
      if (pow_cmd.start) begin
         busy_in = 1'b1;
         k_in    = 2'(pow_cmd.n - 3'd1);
         pw_in   = q;
      end else if (busy_ff) begin
         if (k_ff == 2'd0) begin
            busy_in = 1'b0;
         end else begin
            pw_in = prod[2*lsa_pkg::POW_W-2 -: lsa_pkg::POW_W];
            k_in  = k_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         k_ff    <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         k_ff    <= k_in;
      end
      pw_ff <= pw_in;
   end

endmodule
`default_nettype wire

@@ hw/rtl/lattice_seir_agent_step_top.sv @@
`default_nettype none
// Lattice SEIR agent engine: a toroidal grid of cell states, an agent table and
// four population counters, driven one command word at a time.
// req channel: one command word (place, move or update an agent). rsp channel:
// one result word per command with flags, agent state and the four counts.
// csr port: csr_we writes csr_wdata into register csr_addr
// (0 grid side, 1 infection, 2 onset, 3 recovery probability, Q0.16).
// After reset the block sweeps grid and agent memories to zero, one entry a
// cycle, over the deeper of the two memories; req_tready stays low meanwhile,
// csr writes are taken.
// A command passes through index reduction, the agent table read and decode.
// A place then checks the target cell and writes it; a move checks the target,
// fills it and clears the old cell; an update that changes a state writes it.
// Rejected places, blocked moves, zero steps, unknown commands, unplaced and
// recovered agents end early. A susceptible agent first makes four neighbor
// reads on the single grid read port, then with n infected neighbors the
// multiplier forms (1-beta)^n. One command is in flight at a time.
// A finished word waits in the rsp register; a new command is accepted while
// it waits, and the next result holds in the final state until rsp drains.
module lattice_seir_agent_step_top #(
   parameter int GRID_MAX  = lsa_pkg::GRID_MAX_DEF,
   parameter int AGENT_MAX = lsa_pkg::AGENT_MAX_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // cmd[1:0] agent_index[11:2] place_x[17:12] place_y[23:18] init_state[26:24]
   // move_step[28:27] move_axis[29] draw[45:30]
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   input  wire logic [lsa_pkg::REQ_W-1:0]    req_tdata,
   // status[0] moved[1] changed[2] agent_state[5:3] s_count[16:6]
   // e_count[27:17] i_count[38:28] r_count[49:39]
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   output logic [lsa_pkg::RSP_W-1:0]         rsp_tdata,
   input  wire logic                         csr_we,
   input  wire logic [lsa_pkg::CSR_AW-1:0]   csr_addr,
   input  wire logic [lsa_pkg::CSR_DW-1:0]   csr_wdata
);

   localparam int CW    = $clog2(GRID_MAX);
   localparam int SW    = ($clog2(GRID_MAX + 1) > 7) ? $clog2(GRID_MAX + 1) : 7;
   localparam int GD    = GRID_MAX * GRID_MAX;
   localparam int GAW   = $clog2(GD);
   localparam int AGW   = $clog2(AGENT_MAX);
   localparam int IXW   = (AGW > 10) ? AGW : 10;
   localparam int CLRD  = (GD > AGENT_MAX) ? GD : AGENT_MAX;
   localparam int CLRW  = $clog2(CLRD);
   localparam int AWD   = 4 + 2 * CW;
   localparam int RECIP = (1 << 20) / AGENT_MAX;

   // ---- functions on grid coordinates ----
   function automatic logic [CW-1:0] wrap_fn(input logic [CW-1:0] c, input logic inc,
                                             input logic dec, input logic [SW-1:0] s);
      logic [SW-1:0] cw;
      logic [SW-1:0] r;
      cw = SW'(c);
      if (dec) begin
         if (cw == SW'(0))            r = s - SW'(1);
         else if (cw - SW'(1) >= s)   r = SW'(0);
         else                         r = cw - SW'(1);
      end else if (inc) begin
         r = (cw + SW'(1) >= s) ? SW'(0) : cw + SW'(1);
      end else begin
         r = (cw >= s) ? SW'(0) : cw;
      end
      return r[CW-1:0];
   endfunction

   function automatic logic [GAW-1:0] cell_fn(input logic [CW-1:0] r, input logic [CW-1:0] c);
      return GAW'(r) * GAW'(GRID_MAX) + GAW'(c);
   endfunction

   function automatic logic [1:0] cnt_sel_fn(input logic [2:0] st);
      logic [1:0] k;
      unique case (st)
         lsa_pkg::HS_S: k = 2'd0;
         lsa_pkg::HS_E: k = 2'd1;
         lsa_pkg::HS_I: k = 2'd2;
         default:       k = 2'd3;
      endcase
      return k;
   endfunction

   // ---- configuration ----
   logic [6:0]                  side_ff;
   logic [lsa_pkg::PROB_W-1:0]  infect_ff, onset_ff, recover_ff;
   logic [SW-1:0]               side_ext, side;

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff    <= lsa_pkg::SIDE_RESET;
         infect_ff  <= '0;
         onset_ff   <= '0;
         recover_ff <= '0;
      end else if (csr_we) begin
         unique case (lsa_pkg::csr_reg_type'(csr_addr))
            lsa_pkg::REG_GRID_SIDE: side_ff    <= csr_wdata[6:0];
            lsa_pkg::REG_INFECT:    infect_ff  <= csr_wdata;
            lsa_pkg::REG_ONSET:     onset_ff   <= csr_wdata;
            lsa_pkg::REG_RECOVER:   recover_ff <= csr_wdata;
         endcase
      end
   end

   // clamp the side in use to [2, GRID_MAX]
   assign side_ext = SW'(side_ff);
   assign side = (side_ext < SW'(2)) ? SW'(2) :
                 ((side_ext > SW'(GRID_MAX)) ? SW'(GRID_MAX) : side_ext);

   // ---- memories ----
   logic [2:0]      grid_ff [GD];
   logic [AWD-1:0]  agent_ff [AGENT_MAX];
   logic [2:0]      grid_rd_ff;
   logic [AWD-1:0]  agent_rd_ff;
   logic            grid_we, agent_we;
   logic [GAW-1:0]  grid_wa, grid_ra;
   logic [2:0]      grid_wd;
   logic [AGW-1:0]  agent_wa, agent_ra;
   logic [AWD-1:0]  agent_wd;

   always_ff @(posedge clock) begin
      if (grid_we) begin
         grid_ff[grid_wa] <= grid_wd;
      end
      grid_rd_ff <= grid_ff[grid_ra];
   end

   always_ff @(posedge clock) begin
      if (agent_we) begin
         agent_ff[agent_wa] <= agent_wd;
      end
      agent_rd_ff <= agent_ff[agent_ra];
   end

   // ---- command word fields ----
   logic [1:0]  cmd_ff;
   logic [9:0]  idx_ff;
   logic [5:0]  x_ff, y_ff;
   logic [2:0]  init_ff;
   logic [1:0]  step_ff;
   logic        axis_ff;
   logic [lsa_pkg::PROB_W-1:0] draw_ff;
   logic        req_fire;

   assign req_fire = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff  <= req_tdata[1:0];
         idx_ff  <= req_tdata[11:2];
         x_ff    <= req_tdata[17:12];
         y_ff    <= req_tdata[23:18];
         init_ff <= req_tdata[26:24];
         step_ff <= req_tdata[28:27];
         axis_ff <= req_tdata[29];
         draw_ff <= req_tdata[45:30];
      end
   end

   // ---- sequencer state ----
   lsa_pkg::state_type state_ff, state_in;
   logic [CLRW-1:0]  clr_ff, clr_in;
   logic [9:0]       q_ff, q_in;
   logic [AGW-1:0]   ai_ff, ai_in;
   logic             a_val_ff, a_val_in;
   logic [2:0]       a_st_ff, a_st_in;
   logic [CW-1:0]    a_row_ff, a_row_in, a_col_ff, a_col_in;
   logic [CW-1:0]    tgt_row_ff, tgt_row_in, tgt_col_ff, tgt_col_in;
   logic [2:0]       st_new_ff, st_new_in;
   logic [2:0]       nb_k_ff, nb_k_in, nb_n_ff, nb_n_in;
   logic             status_ff, status_in, moved_ff, moved_in, changed_ff, changed_in;
   logic [lsa_pkg::CNT_W-1:0] cnt_ff [4];
   logic [lsa_pkg::CNT_W-1:0] cnt_in [4];
   logic             inc_en, dec_en;
   logic [1:0]       inc_sel, dec_sel;
   logic             rsp_load;
   logic             rsp_tvalid_ff;
   logic [lsa_pkg::RSP_W-1:0] rsp_tdata_ff;

   lsa_pkg::pow_cmd_type       pow_cmd;
   logic                       pow_done;
   logic [lsa_pkg::POW_W-1:0]  pw, q_beta;

   assign q_beta = lsa_pkg::POW_W'(17'h10000) - {1'b0, infect_ff};

   lsa_pow u_pow (
      .clock    (clock),
      .reset    (reset),
      .pow_cmd  (pow_cmd),
      .q        (q_beta),
      .pow_done (pow_done),
      .pw       (pw)
   );

   // agent index reduced by multiply with a truncated reciprocal and one fixup
   logic [29:0]      recip_prod;
   logic [IXW-1:0]   rem_raw, rem_fix;
   assign recip_prod = {20'd0, idx_ff} * 30'(RECIP);
   assign rem_raw    = IXW'(idx_ff) - IXW'(q_ff) * IXW'(AGENT_MAX);
   assign rem_fix    = ((IXW+1)'(rem_raw) >= (IXW+1)'(AGENT_MAX)) ?
                       rem_raw - IXW'(AGENT_MAX) : rem_raw;

   // fields of the agent word just read
   logic            rd_val;
   logic [2:0]      rd_st;
   logic [CW-1:0]   rd_row, rd_col;
   assign rd_val = agent_rd_ff[AWD-1];
   assign rd_st  = agent_rd_ff[AWD-2 -: 3];
   assign rd_row = agent_rd_ff[2*CW-1 -: CW];
   assign rd_col = agent_rd_ff[CW-1:0];

   // place coordinates saturated to the side, state clamped to S..R
   logic [SW-1:0]   px_ext, py_ext, px_sat, py_sat;
   logic [2:0]      init_clamp;
   assign px_ext = SW'(x_ff);
   assign py_ext = SW'(y_ff);
   assign px_sat = (px_ext >= side) ? side - SW'(1) : px_ext;
   assign py_sat = (py_ext >= side) ? side - SW'(1) : py_ext;
   assign init_clamp = (init_ff == lsa_pkg::HS_EMPTY) ? lsa_pkg::HS_S :
                       ((init_ff > lsa_pkg::HS_R) ? lsa_pkg::HS_R : init_ff);

   // move displacement
   logic step_inc, step_dec;
   assign step_inc = (step_ff == 2'b01);
   assign step_dec = step_ff[1];

   // von Neumann neighbor coordinates; the row neighbors keep the stored column
   logic [CW-1:0] nb_row, nb_col;
   always_comb begin
      unique case (nb_k_ff[1:0])
         2'd0: begin
            nb_row = wrap_fn(a_row_ff, 1'b1, 1'b0, side);
            nb_col = a_col_ff;
         end
         2'd1: begin
            nb_row = wrap_fn(a_row_ff, 1'b0, 1'b1, side);
            nb_col = a_col_ff;
         end
         2'd2: begin
            nb_row = wrap_fn(a_row_ff, 1'b0, 1'b0, side);
            nb_col = wrap_fn(a_col_ff, 1'b1, 1'b0, side);
         end
         default: begin
            nb_row = wrap_fn(a_row_ff, 1'b0, 1'b0, side);
            nb_col = wrap_fn(a_col_ff, 1'b0, 1'b1, side);
         end
      endcase
   end

   logic [2:0]               nb_n_next;
   logic [lsa_pkg::POW_W-1:0] infect_thr;
   assign nb_n_next  = nb_n_ff + ((grid_rd_ff == lsa_pkg::HS_I) ? 3'd1 : 3'd0);
   assign infect_thr = lsa_pkg::POW_W'(17'h10000) - pw;

   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      q_in       = q_ff;
      ai_in      = ai_ff;
      a_val_in   = a_val_ff;
      a_st_in    = a_st_ff;
      a_row_in   = a_row_ff;
      a_col_in   = a_col_ff;
      tgt_row_in = tgt_row_ff;
      tgt_col_in = tgt_col_ff;
      st_new_in  = st_new_ff;
      nb_k_in    = nb_k_ff;
      nb_n_in    = nb_n_ff;
      status_in  = status_ff;
      moved_in   = moved_ff;
      changed_in = changed_ff;
      grid_we    = 1'b0;
      grid_wa    = cell_fn(a_row_ff, a_col_ff);
      grid_wd    = lsa_pkg::HS_EMPTY;
      grid_ra    = cell_fn(tgt_row_ff, tgt_col_ff);
      agent_we   = 1'b0;
      agent_wa   = ai_ff;
      agent_wd   = {1'b1, a_st_ff, a_row_ff, a_col_ff};
      agent_ra   = ai_ff;
      inc_en     = 1'b0;
      inc_sel    = 2'd0;
      dec_en     = 1'b0;
      dec_sel    = 2'd0;
      pow_cmd    = '0;
      rsp_load   = 1'b0;
      req_tready = 1'b0;

      unique case (state_ff)
         lsa_pkg::ST_CLEAR: begin
            grid_we  = ({1'b0, clr_ff} < (CLRW+1)'(GD));
            grid_wa  = clr_ff[GAW-1:0];
            agent_we = ({1'b0, clr_ff} < (CLRW+1)'(AGENT_MAX));
            agent_wa = clr_ff[AGW-1:0];
            agent_wd = '0;
            clr_in   = clr_ff + CLRW'(1);
            if (clr_ff == CLRW'(CLRD - 1)) begin
               state_in = lsa_pkg::ST_IDLE;
            end
         end
         lsa_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_fire) begin
               state_in = lsa_pkg::ST_REDUCE;
            end
         end
         lsa_pkg::ST_REDUCE: begin
            q_in     = recip_prod[29:20];
            state_in = lsa_pkg::ST_AREAD;
         end
         lsa_pkg::ST_AREAD: begin
            ai_in    = rem_fix[AGW-1:0];
            agent_ra = rem_fix[AGW-1:0];
            state_in = lsa_pkg::ST_DECODE;
         end
         lsa_pkg::ST_DECODE: begin
            a_val_in   = rd_val;
            a_st_in    = rd_st;
            a_row_in   = rd_row;
            a_col_in   = rd_col;
            status_in  = 1'b0;
            moved_in   = 1'b0;
            changed_in = 1'b0;
            state_in   = lsa_pkg::ST_DONE;
            unique case (cmd_ff)
               lsa_pkg::CMD_PLACE: begin
                  tgt_row_in = px_sat[CW-1:0];
                  tgt_col_in = py_sat[CW-1:0];
                  st_new_in  = init_clamp;
                  grid_ra    = cell_fn(px_sat[CW-1:0], py_sat[CW-1:0]);
                  state_in   = lsa_pkg::ST_PCHK;
               end
               lsa_pkg::CMD_MOVE: begin
                  if (rd_val && (step_inc || step_dec)) begin
                     tgt_row_in = wrap_fn(rd_row, step_inc && axis_ff,
                                          step_dec && axis_ff, side);
                     tgt_col_in = wrap_fn(rd_col, step_inc && !axis_ff,
                                          step_dec && !axis_ff, side);
                     grid_ra    = cell_fn(tgt_row_in, tgt_col_in);
                     state_in   = lsa_pkg::ST_MCHK;
                  end
               end
               lsa_pkg::CMD_UPDATE: begin
                  if (rd_val) begin
                     if (rd_st == lsa_pkg::HS_S) begin
                        nb_k_in  = 3'd0;
                        nb_n_in  = 3'd0;
                        state_in = lsa_pkg::ST_NB;
                     end else if (rd_st == lsa_pkg::HS_E) begin
                        changed_in = (draw_ff < onset_ff);
                        state_in   = lsa_pkg::ST_UWR;
                     end else if (rd_st == lsa_pkg::HS_I) begin
                        changed_in = (draw_ff < recover_ff);
                        state_in   = lsa_pkg::ST_UWR;
                     end
                  end
               end
               default: begin
                  state_in = lsa_pkg::ST_DONE;
               end
            endcase
         end
         lsa_pkg::ST_PCHK: begin
            if (grid_rd_ff != lsa_pkg::HS_EMPTY) begin
               status_in = 1'b1;
               state_in  = lsa_pkg::ST_DONE;
            end else begin
               // free the old cell of an agent placed again
               grid_we  = a_val_ff;
               state_in = lsa_pkg::ST_PSET;
            end
         end
         lsa_pkg::ST_PSET: begin
            grid_we  = 1'b1;
            grid_wa  = cell_fn(tgt_row_ff, tgt_col_ff);
            grid_wd  = st_new_ff;
            agent_we = 1'b1;
            agent_wd = {1'b1, st_new_ff, tgt_row_ff, tgt_col_ff};
            dec_en   = a_val_ff;
            dec_sel  = cnt_sel_fn(a_st_ff);
            inc_en   = 1'b1;
            inc_sel  = cnt_sel_fn(st_new_ff);
            a_val_in = 1'b1;
            a_st_in  = st_new_ff;
            a_row_in = tgt_row_ff;
            a_col_in = tgt_col_ff;
            state_in = lsa_pkg::ST_DONE;
         end
         lsa_pkg::ST_MCHK: begin
            if (grid_rd_ff == lsa_pkg::HS_EMPTY) begin
               grid_we  = 1'b1;
               grid_wa  = cell_fn(tgt_row_ff, tgt_col_ff);
               grid_wd  = a_st_ff;
               moved_in = 1'b1;
               state_in = lsa_pkg::ST_MCLR;
            end else begin
               state_in = lsa_pkg::ST_DONE;
            end
         end
         lsa_pkg::ST_MCLR: begin
            grid_we  = 1'b1;
            agent_we = 1'b1;
            agent_wd = {1'b1, a_st_ff, tgt_row_ff, tgt_col_ff};
            a_row_in = tgt_row_ff;
            a_col_in = tgt_col_ff;
            state_in = lsa_pkg::ST_DONE;
         end
         lsa_pkg::ST_NB: begin
            // issue neighbor k and count neighbor k-1, whose read is now registered
            grid_ra = cell_fn(nb_row, nb_col);
            nb_k_in = nb_k_ff + 3'd1;
            if (nb_k_ff != 3'd0) begin
               nb_n_in = nb_n_next;
            end
            if (nb_k_ff == 3'd4) begin
               if (nb_n_next == 3'd0) begin
                  state_in = lsa_pkg::ST_DONE;
               end else begin
                  pow_cmd.start = 1'b1;
                  pow_cmd.n     = nb_n_next;
                  state_in      = lsa_pkg::ST_POW;
               end
            end
         end
         lsa_pkg::ST_POW: begin
            if (pow_done) begin
               changed_in = ({1'b0, draw_ff} < infect_thr);
               state_in   = lsa_pkg::ST_UWR;
            end
         end
         lsa_pkg::ST_UWR: begin
            if (changed_ff) begin
               grid_we  = 1'b1;
               grid_wd  = a_st_ff + 3'd1;
               agent_we = 1'b1;
               agent_wd = {1'b1, a_st_ff + 3'd1, a_row_ff, a_col_ff};
               dec_en   = 1'b1;
               dec_sel  = cnt_sel_fn(a_st_ff);
               inc_en   = 1'b1;
               inc_sel  = cnt_sel_fn(a_st_ff + 3'd1);
               a_st_in  = a_st_ff + 3'd1;
            end
            state_in = lsa_pkg::ST_DONE;
         end
         lsa_pkg::ST_DONE: begin
            // hold until the rsp register is free
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = lsa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lsa_pkg::ST_IDLE;
         end
      endcase
   end

   // population counters, one increment and one decrement per cycle
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         cnt_in[i] = cnt_ff[i]
                   + ((inc_en && (inc_sel == 2'(i))) ? 11'd1 : 11'd0)
                   - ((dec_en && (dec_sel == 2'(i))) ? 11'd1 : 11'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lsa_pkg::ST_CLEAR;
         clr_ff   <= '0;
         for (int i = 0; i < 4; i++) begin
            cnt_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         for (int i = 0; i < 4; i++) begin
            cnt_ff[i] <= cnt_in[i];
         end
      end
      q_ff       <= q_in;
      ai_ff      <= ai_in;
      a_val_ff   <= a_val_in;
      a_st_ff    <= a_st_in;
      a_row_ff   <= a_row_in;
      a_col_ff   <= a_col_in;
      tgt_row_ff <= tgt_row_in;
      tgt_col_ff <= tgt_col_in;
      st_new_ff  <= st_new_in;
      nb_k_ff    <= nb_k_in;
      nb_n_ff    <= nb_n_in;
      status_ff  <= status_in;
      moved_ff   <= moved_in;
      changed_ff <= changed_in;
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
      if (rsp_load) begin
         rsp_tdata_ff <= {6'd0, cnt_ff[3], cnt_ff[2], cnt_ff[1], cnt_ff[0],
                          (a_val_ff ? a_st_ff : lsa_pkg::HS_EMPTY),
                          changed_ff, moved_ff, status_ff};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule
`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tb;

   localparam int  CYCLE_LIMIT = 400000;
   localparam int  DRAIN_CYCLES = 30;
   // command code that the block must ignore
   localparam logic [1:0] CMD_NONE = 2'd3;
   // move step encodings
   localparam logic [1:0] STEP_HOLD = 2'b00;
   localparam logic [1:0] STEP_FWD  = 2'b01;
   localparam logic [1:0] STEP_BK2  = 2'b10;
   localparam logic [1:0] STEP_BACK = 2'b11;
   localparam logic AXIS_ROW = 1'b1;
   localparam logic AXIS_COL = 1'b0;

   typedef struct {
      logic [1:0]  cmd;
      logic [9:0]  agent;
      logic [5:0]  px;
      logic [5:0]  py;
      logic [2:0]  init;
      logic [1:0]  step;
      logic        axis;
      logic [15:0] draw;
   } cmd_word_type;

   typedef struct {
      logic        status;
      logic        moved;
      logic        changed;
      logic [2:0]  hstate;
      logic [10:0] s_cnt, e_cnt, i_cnt, r_cnt;
   } outcome_type;

   typedef struct {
      cmd_word_type w;
      outcome_type  res;
   } pending_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [lsa_pkg::REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [lsa_pkg::RSP_W-1:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [lsa_pkg::CSR_AW-1:0] csr_addr = '0;
   logic [lsa_pkg::CSR_DW-1:0] csr_wdata = '0;

   lattice_seir_agent_step_top uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Lattice mirror: grid, agent table, population counts and registers.
   // ---------------------------------------------------------------------
   logic [2:0]  cell_q [0:4095];
   int          ag_row [0:1023];
   int          ag_col [0:1023];
   logic [2:0]  ag_st  [0:1023];
   bit          ag_on  [0:1023];
   logic [10:0] pop    [1:4];
   logic [6:0]  side_reg = 7'd64;
   logic [15:0] beta_reg = '0, sigma_reg = '0, gamma_reg = '0;

   pending_type pend_q[$];
   outcome_type due_q[$];
   int          errors = 0;
   int          cycles = 0;
   int          acc_cnt = 0, drv_cnt = 0, rsp_cnt = 0, rsp_seen = 0;
   int          req_gap = 0, rsp_stall = 0;
   bit          req_fast = 0, rsp_fast = 0;

   function automatic int side_eff();
      int s;
      s = int'(side_reg);
      if (s < 2) s = 2;
      if (s > 64) s = 64;
      return s;
   endfunction

   function automatic int cell_ix(int r, int c);
      return (r % 64) * 64 + (c % 64);
   endfunction

   function automatic int wrap_coord(int c, int d);
      int s;
      s = side_eff();
      if (d < 0) return (c == 0) ? s - 1 : ((c - 1 >= s) ? 0 : c - 1);
      if (d > 0) return (c + 1 >= s) ? 0 : c + 1;
      return (c >= s) ? 0 : c;
   endfunction

   function automatic bit hot(int r, int c);
      return cell_q[cell_ix(r, c)] == lsa_pkg::HS_I;
   endfunction

   function automatic int pop_ix(logic [2:0] st);
      return (st >= lsa_pkg::HS_S && st <= lsa_pkg::HS_I) ? int'(st) : 4;
   endfunction

   // Apply one command to the mirror and return the word the block should send.
   function automatic outcome_type apply_command(cmd_word_type w);
      outcome_type o;
      int a, r, c, s, d, n, k;
      logic [2:0] st;
      longint unsigned q, pw;
      bit fire;
      o = '{default: '0};
      a = int'(w.agent);
      if (w.cmd == lsa_pkg::CMD_PLACE) begin
         s = side_eff();
         r = (int'(w.px) >= s) ? s - 1 : int'(w.px);
         c = (int'(w.py) >= s) ? s - 1 : int'(w.py);
         st = (w.init < lsa_pkg::HS_S) ? lsa_pkg::HS_S :
              ((w.init > lsa_pkg::HS_R) ? lsa_pkg::HS_R : w.init);
         if (cell_q[cell_ix(r, c)] != lsa_pkg::HS_EMPTY) begin
            o.status = 1'b1;
         end else begin
            if (ag_on[a]) begin
               cell_q[cell_ix(ag_row[a], ag_col[a])] = lsa_pkg::HS_EMPTY;
               pop[pop_ix(ag_st[a])] -= 11'd1;
            end
            ag_row[a] = r; ag_col[a] = c; ag_st[a] = st; ag_on[a] = 1;
            cell_q[cell_ix(r, c)] = st;
            pop[pop_ix(st)] += 11'd1;
         end
      end else if (w.cmd == lsa_pkg::CMD_MOVE && ag_on[a]) begin
         d = (w.step == STEP_HOLD) ? 0 : ((w.step == STEP_FWD) ? 1 : -1);
         if (d != 0) begin
            if (w.axis == AXIS_ROW) begin
               r = wrap_coord(ag_row[a], d); c = wrap_coord(ag_col[a], 0);
            end else begin
               r = wrap_coord(ag_row[a], 0); c = wrap_coord(ag_col[a], d);
            end
            if (cell_q[cell_ix(r, c)] == lsa_pkg::HS_EMPTY) begin
               cell_q[cell_ix(r, c)] = cell_q[cell_ix(ag_row[a], ag_col[a])];
               cell_q[cell_ix(ag_row[a], ag_col[a])] = lsa_pkg::HS_EMPTY;
               ag_row[a] = r; ag_col[a] = c;
               o.moved = 1'b1;
            end
         end
      end else if (w.cmd == lsa_pkg::CMD_UPDATE && ag_on[a] &&
                   ag_st[a] >= lsa_pkg::HS_S && ag_st[a] <= lsa_pkg::HS_I) begin
         fire = 0;
         if (ag_st[a] == lsa_pkg::HS_S) begin
            r = ag_row[a]; c = ag_col[a];
            n = hot(wrap_coord(r, 1), c) + hot(wrap_coord(r, -1), c)
              + hot(wrap_coord(r, 0), wrap_coord(c, 1))
              + hot(wrap_coord(r, 0), wrap_coord(c, -1));
            if (n > 0) begin
               q = 65536 - beta_reg;
               pw = q;
               for (k = 1; k < n; k++) pw = (pw * q) >> 16;
               fire = longint'(w.draw) < 65536 - pw;
            end
         end else if (ag_st[a] == lsa_pkg::HS_E) begin
            fire = w.draw < sigma_reg;
         end else begin
            fire = w.draw < gamma_reg;
         end
         if (fire) begin
            pop[pop_ix(ag_st[a])] -= 11'd1;
            ag_st[a] = ag_st[a] + 3'd1;
            pop[pop_ix(ag_st[a])] += 11'd1;
            cell_q[cell_ix(ag_row[a], ag_col[a])] = ag_st[a];
            o.changed = 1'b1;
         end
      end
      o.hstate = ag_on[a] ? ag_st[a] : lsa_pkg::HS_EMPTY;
      o.s_cnt = pop[1]; o.e_cnt = pop[2]; o.i_cnt = pop[3]; o.r_cnt = pop[4];
      return o;
   endfunction

   // Predict now, in stream order; the expectation goes live on acceptance.
   task automatic queue_word(cmd_word_type w);
      pending_type p;
      p.w = w;
      p.res = apply_command(w);
      pend_q.push_back(p);
   endtask

   task automatic csr_write(lsa_pkg::csr_reg_type idx, logic [15:0] v);
      @(negedge clock);
      csr_we <= 1'b1; csr_addr <= idx; csr_wdata <= v;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         lsa_pkg::REG_GRID_SIDE: side_reg  = v[6:0];
         lsa_pkg::REG_INFECT:    beta_reg  = v;
         lsa_pkg::REG_ONSET:     sigma_reg = v;
         lsa_pkg::REG_RECOVER:   gamma_reg = v;
      endcase
   endtask

   // Hold until every queued word is taken and every result has drained.
   task automatic wait_quiet();
      while (pend_q.size() != 0 || due_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic cmd_word_type mk(logic [1:0] cmd, int agent, int px, int py,
                                       int init, logic [1:0] step, logic axis, int draw);
      cmd_word_type w;
      w.cmd = cmd; w.agent = 10'(agent); w.px = 6'(px); w.py = 6'(py); w.init = 3'(init);
      w.step = step; w.axis = axis; w.draw = 16'(draw);
      return w;
   endfunction

   function automatic logic [15:0] pick_prob();
      case ($urandom_range(0, 3))
         0: return 16'd0;
         1: return 16'hFFFF;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   // Random word: mostly commands on placed agents of a small pool so the
   // grid gets crowded enough for contact, blocked moves and rejected places.
   function automatic cmd_word_type rand_word(int pool);
      cmd_word_type w;
      int pick;
      w.agent = ($urandom_range(0, 15) == 0) ? 10'($urandom_range(0, 1023))
                                             : 10'($urandom_range(0, pool - 1));
      w.px = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                         : 6'($urandom_range(0, side_eff() - 1));
      w.py = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                         : 6'($urandom_range(0, side_eff() - 1));
      w.init = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7))
             : (($urandom_range(0, 2) == 0) ? lsa_pkg::HS_I : 3'($urandom_range(1, 4)));
      w.step = 2'($urandom_range(0, 3));
      w.axis = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 5))
         0: w.draw = 16'd0;
         1: w.draw = 16'hFFFF;
         default: w.draw = 16'($urandom_range(0, 65535));
      endcase
      pick = int'($urandom_range(0, 99));
      if (pick < 2) w.cmd = CMD_NONE;
      else if (pick < 30) w.cmd = lsa_pkg::CMD_PLACE;
      else if (pick < 60) w.cmd = lsa_pkg::CMD_MOVE;
      else w.cmd = lsa_pkg::CMD_UPDATE;
      // never address a table entry that was never written
      if (w.cmd != lsa_pkg::CMD_PLACE && !ag_on[w.agent]) w.cmd = lsa_pkg::CMD_PLACE;
      return w;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus: reset, directed phase, then random phases with new settings.
   // ---------------------------------------------------------------------
   initial begin
      int ph, k, pool, sel;
      foreach (cell_q[i]) cell_q[i] = lsa_pkg::HS_EMPTY;
      foreach (ag_on[i]) begin
         ag_on[i] = 0; ag_row[i] = 0; ag_col[i] = 0; ag_st[i] = lsa_pkg::HS_EMPTY;
      end
      foreach (pop[i]) pop[i] = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // 4x4 torus so every placement has neighbors
      csr_write(lsa_pkg::REG_GRID_SIDE, 16'd4);
      csr_write(lsa_pkg::REG_INFECT, 16'd40000);
      csr_write(lsa_pkg::REG_ONSET, 16'd30000);
      csr_write(lsa_pkg::REG_RECOVER, 16'hFFFF);
      queue_word(mk(lsa_pkg::CMD_PLACE, 0, 0, 0, lsa_pkg::HS_S, STEP_HOLD, AXIS_COL, 0));
      queue_word(mk(lsa_pkg::CMD_PLACE, 1023, 63, 63, lsa_pkg::HS_I, STEP_HOLD, AXIS_COL,
                    0)); // saturate
      queue_word(mk(lsa_pkg::CMD_PLACE, 5, 0, 1, 0, STEP_HOLD, AXIS_COL, 0)); // state 0 -> S
      queue_word(mk(lsa_pkg::CMD_PLACE, 6, 0, 0, lsa_pkg::HS_S, STEP_HOLD, AXIS_COL,
                    0)); // occupied
      queue_word(mk(lsa_pkg::CMD_PLACE, 7, 1, 0, 7, STEP_HOLD, AXIS_COL, 0)); // 7 -> R
      queue_word(mk(lsa_pkg::CMD_PLACE, 8, 2, 2, lsa_pkg::HS_E, STEP_HOLD, AXIS_COL, 0));
      queue_word(mk(lsa_pkg::CMD_UPDATE, 0, 0, 0, 0, STEP_HOLD, AXIS_COL,
                    0)); // no infected near
      queue_word(mk(lsa_pkg::CMD_PLACE, 9, 0, 3, lsa_pkg::HS_I, STEP_HOLD, AXIS_COL,
                    0)); // neighbor of (0,0) across the wrap
      queue_word(mk(lsa_pkg::CMD_UPDATE, 0, 0, 0, 0, STEP_HOLD, AXIS_COL, 16'hFFFF));
      queue_word(mk(lsa_pkg::CMD_UPDATE, 0, 0, 0, 0, STEP_HOLD, AXIS_COL, 0));
      queue_word(mk(lsa_pkg::CMD_UPDATE, 8, 0, 0, 0, STEP_HOLD, AXIS_COL, 29999));
      queue_word(mk(lsa_pkg::CMD_UPDATE, 8, 0, 0, 0, STEP_HOLD, AXIS_COL, 30000));
      queue_word(mk(lsa_pkg::CMD_UPDATE, 8, 0, 0, 0, STEP_HOLD, AXIS_COL, 16'hFFFE));
      queue_word(mk(lsa_pkg::CMD_UPDATE, 7, 0, 0, 0, STEP_HOLD, AXIS_COL,
                    0)); // recovered: nothing
      queue_word(mk(lsa_pkg::CMD_MOVE, 5, 0, 0, 0, STEP_BK2, AXIS_COL, 0)); // blocked
      queue_word(mk(lsa_pkg::CMD_MOVE, 5, 0, 0, 0, STEP_FWD, AXIS_COL, 0));
      queue_word(mk(lsa_pkg::CMD_MOVE, 1023, 0, 0, 0, STEP_FWD, AXIS_ROW,
                    0)); // wraps into agent 9
      queue_word(mk(lsa_pkg::CMD_MOVE, 1023, 0, 0, 0, STEP_FWD, AXIS_COL, 0));
      queue_word(mk(lsa_pkg::CMD_MOVE, 1023, 0, 0, 0, STEP_BACK, AXIS_ROW, 0));
      queue_word(mk(lsa_pkg::CMD_MOVE, 1023, 0, 0, 0, STEP_HOLD, AXIS_ROW, 0));
      queue_word(mk(CMD_NONE, 1023, 63, 63, 7, STEP_BK2, AXIS_ROW, 16'hFFFF));
      queue_word(mk(lsa_pkg::CMD_PLACE, 0, 2, 0, lsa_pkg::HS_R, STEP_HOLD, AXIS_COL,
                    0)); // re-place onto an occupied cell
      wait_quiet();

      for (ph = 0; ph < 14; ph++) begin
         sel = int'($urandom_range(0, 9));
         case (sel)
            0: csr_write(lsa_pkg::REG_GRID_SIDE, 16'd0);
            1: csr_write(lsa_pkg::REG_GRID_SIDE, 16'd1);
            2: csr_write(lsa_pkg::REG_GRID_SIDE, 16'hFF7F);
            3: csr_write(lsa_pkg::REG_GRID_SIDE, 16'd64);
            4: csr_write(lsa_pkg::REG_GRID_SIDE, 16'd2);
            default: csr_write(lsa_pkg::REG_GRID_SIDE,
                               {9'($urandom_range(0, 511)), 7'($urandom_range(3, 9))});
         endcase
         if (ph == 1) csr_write(lsa_pkg::REG_INFECT, 16'hFFFF);
         else if (ph == 2) csr_write(lsa_pkg::REG_INFECT, 16'd0);
         else csr_write(lsa_pkg::REG_INFECT, pick_prob());
         csr_write(lsa_pkg::REG_ONSET, pick_prob());
         csr_write(lsa_pkg::REG_RECOVER, pick_prob());
         pool = (side_eff() * side_eff() < 64) ? side_eff() * side_eff() + 2
                                               : int'($urandom_range(8, 64));
         for (k = 0; k < 110; k++) queue_word(rand_word(pool));
         wait_quiet();
      end

      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // ---------------------------------------------------------------------
   // Request driver: change on the falling edge, one assignment per step.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      logic nxt;
      nxt = 1'b0;
      if (reset) begin
         nxt = 1'b0;
      end else if (req_tvalid && acc_cnt == drv_cnt) begin
         nxt = 1'b1;  // hold until taken
      end else begin
         if (req_tvalid) begin
            drv_cnt = acc_cnt;
            if ($urandom_range(0, 40) == 0) req_fast = ~req_fast;
            req_gap = req_fast ? 0 : int'($urandom_range(0, 17));
         end
         if (req_gap > 0) begin
            req_gap--;
         end else if (pend_q.size() != 0) begin
            nxt = 1'b1;
            req_tdata <= {2'b00, pend_q[0].w.draw, pend_q[0].w.axis, pend_q[0].w.step,
                          pend_q[0].w.init, pend_q[0].w.py, pend_q[0].w.px,
                          pend_q[0].w.agent, pend_q[0].w.cmd};
         end
      end
      req_tvalid <= nxt;
   end

   // Result back-pressure: fresh stall per word, with stall-free stretches.
   always @(negedge clock) begin
      if (rsp_cnt != rsp_seen) begin
         rsp_seen = rsp_cnt;
         if ($urandom_range(0, 40) == 0) rsp_fast = ~rsp_fast;
         rsp_stall = rsp_fast ? 0 : int'($urandom_range(0, 17));
      end
      if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         errors++;
         $display("%0t: mismatch %s expected %0d actual %0d", $realtime, name, want, got);
      end
   endtask

   // ---------------------------------------------------------------------
   // Monitor: sample on the rising edge, arm expectations, compare results.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      outcome_type want;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else if (!reset) begin
         if (req_tvalid && req_tready) begin
            due_q.push_back(pend_q[0].res);
            pend_q.pop_front();
            acc_cnt++;
         end
         if (rsp_tvalid && rsp_tready) begin
            rsp_cnt++;
            if (due_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected result word %h", $realtime, rsp_tdata);
            end else begin
               want = due_q.pop_front();
               check_field("status",  int'(want.status),  int'(rsp_tdata[0]));
               check_field("moved",   int'(want.moved),   int'(rsp_tdata[1]));
               check_field("changed", int'(want.changed), int'(rsp_tdata[2]));
               check_field("agent_state", int'(want.hstate), int'(rsp_tdata[5:3]));
               check_field("s_count", int'(want.s_cnt), int'(rsp_tdata[16:6]));
               check_field("e_count", int'(want.e_cnt), int'(rsp_tdata[27:17]));
               check_field("i_count", int'(want.i_cnt), int'(rsp_tdata[38:28]));
               check_field("r_count", int'(want.r_cnt), int'(rsp_tdata[49:39]));
            end
         end
      end
   end

endmodule
`default_nettype wire

@@ filelist.f @@
hw/rtl/lsa_pkg.sv
hw/rtl/lsa_pow.sv
hw/rtl/lattice_seir_agent_step_top.sv
dv/tb.sv
